/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int FUNC_W    = 3;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int REMOVED_W = 5;
  localparam int OCC_W     = 5;

  localparam logic [FUNC_W-1:0] FUNC_OFFER      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL       = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_ALL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_PURGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     index;
    logic [CNT_W-1:0]     count;
    logic                 descending;
  } cell_ctl_t;

endpackage

/* design/spq_if.sv */
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for requests, results and the order register.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::FUNC_W-1:0]    func;
  logic [spq_pkg::KEY_WIDTH-1:0] key_in;
  logic [spq_pkg::INDEX_W-1:0]   index_in;

  modport source (output valid, func, key_in, index_in, input ready);
  modport sink   (input valid, func, key_in, index_in, output ready);
endinterface

interface spq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::STATUS_W-1:0]   status;
  logic [spq_pkg::KEY_WIDTH-1:0]  key_out;
  logic [spq_pkg::POS_W-1:0]      position;
  logic [spq_pkg::REMOVED_W-1:0]  removed_count;
  logic [spq_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, status, key_out, position, removed_count, occupancy,
                  input ready);
  modport sink   (input valid, status, key_out, position, removed_count, occupancy,
                  output ready);
endinterface

interface spq_cfg_if;
  logic valid;
  logic ready;
  logic descending_order;

  modport source (output valid, descending_order, input ready);
  modport sink   (input valid, descending_order, output ready);
endinterface

/* design/sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted-list priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Offer, poll, read-at and remove-at complete in the cycle that takes the
// request: every cell compares its key with the broadcast key at once and,
// for all but read-at, the row shifts by one place in that cycle. Remove-all
// first takes the request and then, while a stored key still matches, drops
// the first matching key in each cycle, and it writes its result once no
// match is left. A request is taken whenever no remove-all is running and
// the result register is empty or its result is being taken in the same
// cycle. The order register can be written at any time and takes effect
// for later offers; stored keys are not sorted again.
module sorted_priority_queue_core (
  input  logic            clk,
  input  logic            rst,
  spq_req_if.sink         request,
  spq_rsp_if.source       result,
  spq_cfg_if.sink         cfg
);

  typedef enum logic {S_IDLE, S_PURGE} state_t;

  state_t                          state;
  logic [spq_pkg::CNT_W-1:0]       count;
  logic [spq_pkg::CNT_W-1:0]       count_next;
  logic                            descending;
  logic [spq_pkg::KEY_WIDTH-1:0]   purge_key;
  logic [spq_pkg::CNT_W-1:0]       purge_removed;

  logic                            out_valid;
  logic                            out_load;
  logic [spq_pkg::STATUS_W-1:0]    out_status;
  logic [spq_pkg::KEY_WIDTH-1:0]   out_key;
  logic [spq_pkg::POS_W-1:0]       out_position;
  logic [spq_pkg::REMOVED_W-1:0]   out_removed;
  logic [spq_pkg::OCC_W-1:0]       out_occupancy;

  spq_pkg::cell_ctl_t              ctl;
  logic [spq_pkg::KEY_WIDTH-1:0]   cell_key [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH:0]         chain;
  logic [spq_pkg::DEPTH-1:0]       first;

  logic                            accept;
  logic                            full;
  logic                            empty;
  logic                            in_range;
  logic [spq_pkg::CNT_W-1:0]       sel_index;
  logic [spq_pkg::KEY_WIDTH-1:0]   key_at;
  logic [spq_pkg::POS_W-1:0]       pos_enc;
  logic [spq_pkg::STATUS_W-1:0]    res_status;
  logic [spq_pkg::KEY_WIDTH-1:0]   res_key;

  assign request.ready = (state == S_IDLE) && (!out_valid || result.ready);
  assign cfg.ready     = 1'b1;
  assign accept        = request.valid && request.ready;

  assign full     = count == spq_pkg::CNT_W'(spq_pkg::DEPTH);
  assign empty    = count == '0;
  assign in_range = 32'(request.index_in) < 32'(count);
  assign sel_index = (request.func == spq_pkg::FUNC_POLL) ? '0
                                                          : spq_pkg::CNT_W'(request.index_in);

  assign out_load = ((state == S_IDLE) && accept &&
                     (request.func != spq_pkg::FUNC_REMOVE_ALL)) ||
                    ((state == S_PURGE) && !chain[spq_pkg::DEPTH]);

  always_comb begin
    ctl.op         = spq_pkg::CELL_HOLD;
    ctl.key        = request.key_in;
    ctl.index      = sel_index;
    ctl.count      = count;
    ctl.descending = descending;
    if (state == S_PURGE) begin
      ctl.op  = spq_pkg::CELL_PURGE;
      ctl.key = purge_key;
    end else if (accept) begin
      case (request.func)
        spq_pkg::FUNC_OFFER:     if (!full) ctl.op = spq_pkg::CELL_INSERT;
        spq_pkg::FUNC_POLL:      if (!empty) ctl.op = spq_pkg::CELL_DELETE;
        spq_pkg::FUNC_REMOVE_AT: if (in_range) ctl.op = spq_pkg::CELL_DELETE;
        default:                 ctl.op = spq_pkg::CELL_HOLD;
      endcase
    end
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    logic [spq_pkg::KEY_WIDTH-1:0] left_key;
    logic [spq_pkg::KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = '0;
    end else begin : g_body
      assign left_key = cell_key[i-1];
    end
    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (spq_pkg::IDX_W'(i)),
      .left_key  (left_key),
      .right_key (right_key),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .first     (first[i]),
      .key       (cell_key[i])
    );
  end

  always_comb begin
    key_at  = '0;
    pos_enc = '0;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      if (spq_pkg::CNT_W'(i) == sel_index) key_at |= cell_key[i];
      if (first[i]) pos_enc |= spq_pkg::POS_W'(i);
    end
  end

  always_comb begin
    count_next = count;
    case (ctl.op)
      spq_pkg::CELL_INSERT: count_next = count + 1'b1;
      spq_pkg::CELL_DELETE: count_next = count - 1'b1;
      spq_pkg::CELL_PURGE:  if (chain[spq_pkg::DEPTH]) count_next = count - 1'b1;
      default:              count_next = count;
    endcase
  end

  always_comb begin
    res_status = spq_pkg::STATUS_OK;
    res_key    = '0;
    case (request.func)
      spq_pkg::FUNC_OFFER: if (full) res_status = spq_pkg::STATUS_FULL;
      spq_pkg::FUNC_POLL: begin
        if (empty) res_status = spq_pkg::STATUS_EMPTY;
        else res_key = key_at;
      end
      spq_pkg::FUNC_READ_AT,
      spq_pkg::FUNC_REMOVE_AT: begin
        if (!in_range) res_status = spq_pkg::STATUS_EMPTY;
        else res_key = key_at;
      end
      spq_pkg::FUNC_REMOVE_ALL: res_status = spq_pkg::STATUS_OK;
      default: res_status = spq_pkg::STATUS_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      descending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg.valid && cfg.ready) begin
        descending <= cfg.descending_order;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.func == spq_pkg::FUNC_REMOVE_ALL) begin
              state         <= S_PURGE;
              purge_key     <= request.key_in;
              purge_removed <= '0;
            end else begin
              out_status    <= res_status;
              out_key       <= res_key;
              out_position  <= (ctl.op == spq_pkg::CELL_INSERT) ? pos_enc : '0;
              out_removed   <= '0;
              out_occupancy <= spq_pkg::OCC_W'(count_next);
            end
          end
        end
        S_PURGE: begin
          if (chain[spq_pkg::DEPTH]) begin
            purge_removed <= purge_removed + 1'b1;
          end else begin
            state         <= S_IDLE;
            out_status    <= spq_pkg::STATUS_OK;
            out_key       <= '0;
            out_position  <= '0;
            out_removed   <= spq_pkg::REMOVED_W'(purge_removed);
            out_occupancy <= spq_pkg::OCC_W'(count);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.key_out       = out_key;
  assign result.position      = out_position;
  assign result.removed_count = out_removed;
  assign result.occupancy     = out_occupancy;

endmodule

/* design/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a key, compares it with the broadcast
// key and takes its own, the broadcast, the left or the right key.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                          clk,
  input  spq_pkg::cell_ctl_t            ctl,
  input  logic [spq_pkg::IDX_W-1:0]     slot,
  input  logic [spq_pkg::KEY_WIDTH-1:0] left_key,
  input  logic [spq_pkg::KEY_WIDTH-1:0] right_key,
  input  logic                          chain_in,
  output logic                          chain_out,
  output logic                          first,
  output logic [spq_pkg::KEY_WIDTH-1:0] key
);

  logic                          occupied;
  logic                          at_count;
  logic                          not_smaller;
  logic                          hit;
  logic [spq_pkg::KEY_WIDTH-1:0] key_next;

  assign occupied    = spq_pkg::CNT_W'(slot) < ctl.count;
  assign at_count    = spq_pkg::CNT_W'(slot) == ctl.count;
  assign not_smaller = ctl.descending ? (key <= ctl.key) : (key >= ctl.key);

  always_comb begin
    case (ctl.op)
      spq_pkg::CELL_INSERT: hit = (occupied && not_smaller) || at_count;
      spq_pkg::CELL_DELETE: hit = spq_pkg::CNT_W'(slot) == ctl.index;
      spq_pkg::CELL_PURGE:  hit = occupied && (key == ctl.key);
      default:              hit = 1'b0;
    endcase
  end

  assign chain_out = chain_in | hit;
  assign first     = hit & ~chain_in;

  always_comb begin
    case (ctl.op)
      spq_pkg::CELL_INSERT: key_next = first ? ctl.key : (chain_in ? left_key : key);
      spq_pkg::CELL_DELETE,
      spq_pkg::CELL_PURGE:  key_next = chain_out ? right_key : key;
      default:              key_next = key;
    endcase
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

/* design/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result stream of the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           rsp_valid,
  input logic [spq_pkg::STATUS_W-1:0]   rsp_status,
  input logic [spq_pkg::KEY_WIDTH-1:0]  rsp_key_out,
  input logic [spq_pkg::POS_W-1:0]      rsp_position,
  input logic [spq_pkg::REMOVED_W-1:0]  rsp_removed_count,
  input logic [spq_pkg::OCC_W-1:0]      rsp_occupancy
);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_occupancy) <= spq_pkg::DEPTH)
    else $error("occupancy above depth");

  a_full_at_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == spq_pkg::STATUS_FULL
      |-> 32'(rsp_occupancy) == spq_pkg::DEPTH && rsp_position == '0)
    else $error("full status with room left");

  a_removed_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_removed_count != '0
      |-> rsp_status == spq_pkg::STATUS_OK && rsp_key_out == '0 && rsp_position == '0)
    else $error("remove count mixed with other result fields");

  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (result.valid),
  .rsp_status        (result.status),
  .rsp_key_out       (result.key_out),
  .rsp_position      (result.position),
  .rsp_removed_count (result.removed_count),
  .rsp_occupancy     (result.occupancy)
);
